// File: sv/hud_pkg.sv
// Package for the HCI UART deframer: phase type, kind and role codes, tagged item type.
`default_nettype none

package hud_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_ACL = 2'd0;
	localparam logic [1:0] KIND_SCO = 2'd1;
	localparam logic [1:0] KIND_EVT = 2'd2;

	localparam logic [1:0] ROLE_TYPE    = 2'd0;
	localparam logic [1:0] ROLE_HEADER  = 2'd1;
	localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

	localparam logic [7:0] TYPE_ACL = 8'd2;
	localparam logic [7:0] TYPE_EVT = 8'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic [1:0] role;
		logic       start;
		logic       last;
		logic       bad;
	} hud_item_t;

	// Index of the final header byte for each packet kind.
	function automatic logic [2:0] hdr_last(input logic [1:0] kind);
		logic [2:0] r;
		case (kind)
			KIND_ACL: r = 3'd3;
			KIND_SCO: r = 3'd2;
			default:  r = 3'd1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/hci_uart_packet_deframer_unit.sv
// Top level of the HCI UART packet deframer.
//
//  Channel   Handshake            Payload
//  --------  -------------------  --------------------------------------------------
//  byte in   up_valid / up_stall  rx_byte
//  item out  dn_valid / dn_stall  out_byte, packet_kind, byte_role, packet_start,
//                                 packet_end, bad_type
//
// One byte is taken per cycle while the queue is not full; the packet state updates in the cycle the byte is taken.
// A tagged item is written into the four-entry queue when its byte is taken, and the
// output register takes it from the queue once the register is free.
// up_stall rises only when the queue is full, so a stall downstream reaches the
// input after the output register and queue have filled.
// After reset the deframer waits for a type byte; no clearing pass is needed.
`default_nettype none

module hci_uart_packet_deframer_unit import hud_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       up_valid,
	output logic            up_stall,
	input  wire logic [7:0] rx_byte,
	output logic            dn_valid,
	input  wire logic       dn_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      packet_kind,
	output logic [1:0]      byte_role,
	output logic            packet_start,
	output logic            packet_end,
	output logic            bad_type
);

	hud_item_t front_item;
	hud_item_t q_item;
	hud_item_t dn_item;
	logic      accept;
	logic      q_full;
	logic      q_empty;
	logic      q_pop;

	assign up_stall = q_full;
	assign accept   = up_valid && !q_full;

	hud_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.item    (front_item)
	);

	hud_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_item (front_item),
		.pop       (q_pop),
		.pop_item  (q_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	hud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.dn_stall (dn_stall),
		.dn_valid (dn_valid),
		.dn_item  (dn_item)
	);

	assign out_byte     = dn_item.data;
	assign packet_kind  = dn_item.kind;
	assign byte_role    = dn_item.role;
	assign packet_start = dn_item.start;
	assign packet_end   = dn_item.last;
	assign bad_type     = dn_item.bad;

endmodule

`default_nettype wire

// File: sv/hud_front.sv
// Front part of the deframer: tracks packet phase and tags each received byte.
`default_nettype none

module hud_front import hud_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire logic [7:0] rx_byte,
	output hud_item_t      item
);

	phase_t      phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [2:0]  hidx_q, hidx_d;
	logic [7:0]  lowb_q, lowb_d;
	logic [15:0] left_q, left_d;
	logic [15:0] left_hdr;
	logic [15:0] left_dec;
	logic [2:0]  last_idx;
	logic        hdr_done;
	logic        type_ok;

	assign last_idx = hdr_last(kind_q);
	assign hdr_done = (hidx_q >= last_idx);
	assign left_dec = left_q - 16'd1;
	assign type_ok  = (rx_byte >= TYPE_ACL) && (rx_byte <= TYPE_EVT);

	// Length value as it stands after this header byte.
	always_comb begin
		left_hdr = left_q;
		if (kind_q == KIND_ACL) begin
			if (hidx_q == 3'd3) begin
				left_hdr = {rx_byte, lowb_q};
			end
		end else if (hidx_q == last_idx) begin
			left_hdr = {8'h00, rx_byte};
		end
	end

	// Next state.
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		hidx_d  = hidx_q;
		lowb_d  = lowb_q;
		left_d  = left_q;
		case (phase_q)
			PH_HEADER: begin
				if (kind_q == KIND_ACL && hidx_q == 3'd2) begin
					lowb_d = rx_byte;
				end
				left_d = left_hdr;
				if (hdr_done) begin
					hidx_d  = 3'd0;
					phase_d = (left_hdr == 16'd0) ? PH_IDLE : PH_PAYLOAD;
				end else begin
					hidx_d = hidx_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				if (type_ok) begin
					kind_d  = rx_byte[1:0] - 2'd2;
					hidx_d  = 3'd0;
					left_d  = 16'd0;
					lowb_d  = 8'd0;
					phase_d = PH_HEADER;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Tagging of the current byte.
	always_comb begin
		item       = '0;
		item.data  = rx_byte;
		case (phase_q)
			PH_HEADER: begin
				item.kind = kind_q;
				item.role = ROLE_HEADER;
				item.last = hdr_done && (left_hdr == 16'd0);
			end
			PH_PAYLOAD: begin
				item.kind = kind_q;
				item.role = ROLE_PAYLOAD;
				item.last = (left_dec == 16'd0);
			end
			default: begin
				item.role = ROLE_TYPE;
				if (type_ok) begin
					item.kind  = rx_byte[1:0] - 2'd2;
					item.start = 1'b1;
				end else begin
					item.bad = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= KIND_ACL;
			hidx_q  <= 3'd0;
			lowb_q  <= 8'd0;
			left_q  <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			hidx_q  <= hidx_d;
			lowb_q  <= lowb_d;
			left_q  <= left_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/hud_queue.sv
// Short queue of tagged items between the front and back parts.
`default_nettype none

module hud_queue import hud_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  hud_item_t push_item,
	input  wire logic pop,
	output hud_item_t pop_item,
	output logic      full,
	output logic      empty
);

	hud_item_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q;
	logic [QUEUE_AW-1:0] rptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/hud_back.sv
// Back part of the deframer: output register that hands tagged items downstream.
`default_nettype none

module hud_back import hud_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  hud_item_t q_item,
	output logic      q_pop,
	input  wire logic dn_stall,
	output logic      dn_valid,
	output hud_item_t dn_item
);

	logic      valid_q;
	hud_item_t item_q;
	logic      load;

	// The register takes a new item when it is empty or its item leaves this cycle.
	assign load     = !valid_q || !dn_stall;
	assign q_pop    = load && !q_empty;
	assign dn_valid = valid_q;
	assign dn_item  = item_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !q_empty;
		end
	end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the HCI UART packet deframer, with its own tagging model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hud_pkg::*;

	localparam logic [7:0] TYPE_SCO = 8'd3;
	localparam int RANDOM_BYTES = 100;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int HOLD_AT      = 150;
	localparam int HOLD_CYCLES  = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       up_valid = 1'b0;
	logic       up_stall;
	logic [7:0] rx_byte = 8'd0;
	logic       dn_valid;
	logic       dn_stall = 1'b0;
	logic [7:0] out_byte;
	logic [1:0] packet_kind;
	logic [1:0] byte_role;
	logic       packet_start;
	logic       packet_end;
	logic       bad_type;

	logic [7:0] rx_pending[$];
	hud_item_t  tags_due[$];
	hud_item_t  due_tag;
	bit         failed = 1'b0;
	int         bytes_in = 0;
	int         cyc = 0;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	logic       calm;

	// Framing state of the model.
	phase_t      fr_phase = PH_IDLE;
	logic [1:0]  fr_kind = KIND_ACL;
	logic [2:0]  fr_hdr_idx = 3'd0;
	logic [7:0]  fr_len_lo = 8'd0;
	logic [15:0] fr_left = 16'd0;

	hci_uart_packet_deframer_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (up_valid),
		.up_stall     (up_stall),
		.rx_byte      (rx_byte),
		.dn_valid     (dn_valid),
		.dn_stall     (dn_stall),
		.out_byte     (out_byte),
		.packet_kind  (packet_kind),
		.byte_role    (byte_role),
		.packet_start (packet_start),
		.packet_end   (packet_end),
		.bad_type     (bad_type)
	);

	always #10 clk = ~clk;

	// Neither side idles while this window of input bytes goes through.
	assign calm = (bytes_in >= 250) && (bytes_in < 330);

	function automatic hud_item_t tag_byte(input logic [7:0] b);
		hud_item_t  t;
		logic [2:0] last_idx;
		t.data  = b;
		t.kind  = KIND_ACL;
		t.role  = ROLE_TYPE;
		t.start = 1'b0;
		t.last  = 1'b0;
		t.bad   = 1'b0;
		case (fr_phase)
			PH_HEADER: begin
				last_idx = (fr_kind == KIND_ACL) ? 3'd3 : (fr_kind == KIND_SCO) ? 3'd2 : 3'd1;
				t.kind = fr_kind;
				t.role = ROLE_HEADER;
				if (fr_kind == KIND_ACL) begin
					if (fr_hdr_idx == 3'd2)
						fr_len_lo = b;
					if (fr_hdr_idx == 3'd3)
						fr_left = {b, fr_len_lo};
				end else if (fr_hdr_idx == last_idx) begin
					fr_left = {8'd0, b};
				end
				if (fr_hdr_idx >= last_idx) begin
					fr_hdr_idx = 3'd0;
					// A zero length closes the packet on its last header byte.
					if (fr_left == 16'd0) begin
						t.last = 1'b1;
						fr_phase = PH_IDLE;
					end else begin
						fr_phase = PH_PAYLOAD;
					end
				end else begin
					fr_hdr_idx = fr_hdr_idx + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				t.kind = fr_kind;
				t.role = ROLE_PAYLOAD;
				fr_left = fr_left - 16'd1;
				if (fr_left == 16'd0) begin
					t.last = 1'b1;
					fr_phase = PH_IDLE;
				end
			end
			default: begin
				if (b >= TYPE_ACL && b <= TYPE_EVT) begin
					fr_kind = 2'(b - TYPE_ACL);
					t.kind = fr_kind;
					t.start = 1'b1;
					fr_hdr_idx = 3'd0;
					fr_left = 16'd0;
					fr_len_lo = 8'd0;
					fr_phase = PH_HEADER;
				end else begin
					t.bad = 1'b1;
					fr_phase = PH_IDLE;
				end
			end
		endcase
		return t;
	endfunction

	// Queues one packet; a non-zero cut keeps only that many leading bytes.
	task automatic queue_packet(input logic [7:0] type_byte, input int len, input int cut);
		logic [7:0] pkt[$];
		pkt.push_back(type_byte);
		case (type_byte)
			TYPE_ACL: begin
				pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(len[7:0]);
				pkt.push_back(len[15:8]);
			end
			TYPE_SCO: begin
				pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(len[7:0]);
			end
			default: begin
				pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(len[7:0]);
			end
		endcase
		repeat (len)
			pkt.push_back(8'($urandom_range(255)));
		foreach (pkt[i])
			if (cut == 0 || i < cut)
				rx_pending.push_back(pkt[i]);
	endtask

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			failed = 1'b1;
			$display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// Sender: holds a stalled item, otherwise offers the next byte or idles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (up_valid && !up_stall) begin
				tags_due.push_back(tag_byte(rx_byte));
				bytes_in <= bytes_in + 1;
			end
			if (!up_valid || !up_stall) begin
				if (rx_pending.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
					up_valid <= 1'b1;
					rx_byte <= rx_pending.pop_front();
				end else begin
					up_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off of the receiver, so that the queue fills and the input stalls.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && bytes_in >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver and checker.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dn_valid && !dn_stall) begin
				if (tags_due.size() == 0) begin
					failed = 1'b1;
					$display("%0t ns: item with byte %0h expected none actual one", $time, out_byte);
				end else begin
					due_tag = tags_due.pop_front();
					check_field("out_byte", due_tag.data, out_byte);
					check_field("packet_kind", 8'(due_tag.kind), 8'(packet_kind));
					check_field("byte_role", 8'(due_tag.role), 8'(byte_role));
					check_field("packet_start", 8'(due_tag.start), 8'(packet_start));
					check_field("packet_end", 8'(due_tag.last), 8'(packet_end));
					check_field("bad_type", 8'(due_tag.bad), 8'(bad_type));
				end
			end
			dn_stall <= (hold_left != 0) || (!calm && $urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int         directed;
		int         pick;
		int         len;
		int         cut;
		logic [7:0] type_byte;

		// Bad type bytes at both ends of the range and just beside the valid codes.
		rx_pending.push_back(8'h00);
		rx_pending.push_back(8'hFF);
		rx_pending.push_back(8'h01);
		rx_pending.push_back(8'h05);
		// Empty packets of each kind, then short ones with a payload.
		queue_packet(TYPE_EVT, 0, 0);
		queue_packet(TYPE_SCO, 0, 0);
		queue_packet(TYPE_ACL, 0, 0);
		queue_packet(TYPE_EVT, 1, 0);
		queue_packet(TYPE_SCO, 1, 0);
		queue_packet(TYPE_ACL, 1, 0);
		directed = rx_pending.size();

		// Mostly well-formed packets with random content, some noise and truncated packets.
		while (rx_pending.size() < directed + RANDOM_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				rx_pending.push_back(8'($urandom_range(255)));
			end else begin
				type_byte = TYPE_ACL + 8'($urandom_range(2));
				len = ($urandom_range(5) == 0) ? 0 : $urandom_range(12, 1);
				cut = (pick < 14) ? $urandom_range(4, 1) : 0;
				queue_packet(type_byte, len, cut);
			end
		end
		// Long lengths: an ACL length with only the high byte set, and an SCO packet
		// of the largest 8-bit length, cut short at the end of the stream.
		queue_packet(TYPE_ACL, 16'h0100, 0);
		queue_packet(TYPE_EVT, 0, 0);
		queue_packet(TYPE_SCO, 255, 12);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() != 0 || up_valid) @(posedge clk);
		while (tags_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (!failed) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/hud_pkg.sv
sv/hud_front.sv
sv/hud_queue.sv
sv/hud_back.sv
sv/hci_uart_packet_deframer_unit.sv
tb/tb.sv
